// ----- hw/rtl/hmc_pkg.sv -----
// Package for the heightfield marching cubes block.
// Holds the state type, the corner and edge tables and the triangle list.
// No dependencies.
package hmc_pkg;

  localparam int COORD_BITS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int TRI_CHARS      = 15;

  localparam logic [1:0] REG_ISO_LEVEL    = 2'd0;
  localparam logic [1:0] REG_CHUNK_HEIGHT = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DENS,
    S_LOOK,
    S_SEL,
    S_PREP,
    S_DIV,
    S_VERT,
    S_OUT
  } hmc_state_t;

  typedef struct packed {
    logic [2:0]       ntri;
    logic [14:0][3:0] edges;
  } tri_entry_t;

  // corner offsets: bit0 x, bit1 y, bit2 z
  localparam logic [2:0] CORNER_POS [8] = '{3'd0, 3'd2, 3'd3, 3'd1, 3'd4, 3'd6, 3'd7, 3'd5};
  // edges 12..15 never occur; they map like edge 0
  localparam logic [2:0] EDGE_LO [16] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
                                          3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0};
  localparam logic [2:0] EDGE_HI [16] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4,
                                          3'd4, 3'd5, 3'd6, 3'd7, 3'd1, 3'd1, 3'd1, 3'd1};

  localparam logic [119:0] TRI_LIST [256] = '{
    "","083","019","183981","12a","08312a","92a029","2832a8a98",
    "3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
    "478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
    "8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4","47890b9bab03",
    "47b4b99ba",
    "954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
    "95423b","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba","54050b5bab03",
    "54858aa8b",
    "978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52",
    "2a5253357",
    "7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b","5705097b010aba0",
    "ba0b03a50807570","ba57b5",
    "a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
    "23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6","3b6036065059",
    "65969bb98",
    "5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347","847905065026",
    "739794329596269",
    "3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6",
    "51b5b610b7b404b","059065036b63847","65969b4797b9",
    "a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264","024426",
    "832824426",
    "a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63",
    "8b1810b61914641","3b6360064","648b68",
    "7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867","269291679093739",
    "780706602","732672",
    "23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671","896867916b63136",
    "091b67","7807063b0b60","7b6",
    "76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
    "723627","708760620","276237019","162186198876","a76a17137","a7617a187108","03707a0a96a7",
    "76a7a88a9",
    "684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046","4b846b0292a9",
    "a93a32943b36463",
    "823842462","042462","190234246438","194142246","8138618466a1","a10a06604",
    "4634386a3039a93","a946a4",
    "49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495","76b54a42a402",
    "348354325a52b76",
    "723762549","954086062687","362376150540","628687218485158","954a16176137",
    "16a176107870954","40a4a503a6a737a","76a7a854a48a",
    "6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56","0b306b09656912a",
    "b85b56805a52025","6b36352a3a53",
    "589528562382","956960062","158180568382628","156216","13616a386569896","a10a06950560",
    "03856a","a56",
    "b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b71751","08312717572b","9759279022b7",
    "75272b592328982",
    "25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175",
    "903935537","987597",
    "5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458",
    "04b0b345b2b151b","0250592b5458b85","9452b3",
    "25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105",
    "845853905035","945",
    "4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912",
    "9749b791b2b1083","b74b42240","b74b42834324",
    "29a279237749","9a7974a27870207","37a3a274a1a040a","1a2874","491417713","491417081871",
    "403743","487",
    "9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
    "23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
  };

  // ASCII edge list to edge codes, first edge in slot 0
  function automatic tri_entry_t tri_lookup(input logic [7:0] idx);
    logic [119:0] s;
    logic [7:0]   ch;
    int           len;
    tri_entry_t   r;
    s   = TRI_LIST[idx];
    len = 0;
    r   = '0;
    for (int i = 0; i < TRI_CHARS; i++) begin
      if (s[i*8 +: 8] != 8'd0) len++;
    end
    for (int j = 0; j < TRI_CHARS; j++) begin
      if (j < len) begin
        ch = s[(len-1-j)*8 +: 8];
        r.edges[j] = (ch >= 8'h61) ? 4'(ch - 8'h57) : 4'(ch - 8'h30);
      end
    end
    r.ntri = 3'(len / 3);
    return r;
  endfunction

endpackage

// ----- hw/rtl/heightfield_marching_cubes.sv -----
// Flow: multiply the corner heights by chunk_height, then densities and table lookup, then per
// vertex select, prepare, divide (one quotient bit per cycle), place; up to 5 triangles.
// Throughput: one cube at a time, bounded by the shared 16x8 multiplier, the bit-serial
// divider and output stalls; a new cube is taken only once the last one is done.
// Reset: synchronous rst returns to idle, iso_level 0, chunk_height 64.
// Uses hmc_pkg.
module heightfield_marching_cubes
  import hmc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        cell_x,
  input  logic [7:0]                        cell_y,
  input  logic [7:0]                        cell_z,
  input  logic [15:0]                       height_00,
  input  logic [15:0]                       height_10,
  input  logic [15:0]                       height_01,
  input  logic [15:0]                       height_11,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_BITS+FRAC_BITS:0]     v0_x,
  output logic [COORD_BITS+FRAC_BITS:0]     v0_y,
  output logic [COORD_BITS+FRAC_BITS:0]     v0_z,
  output logic [COORD_BITS+FRAC_BITS:0]     v1_x,
  output logic [COORD_BITS+FRAC_BITS:0]     v1_y,
  output logic [COORD_BITS+FRAC_BITS:0]     v1_z,
  output logic [COORD_BITS+FRAC_BITS:0]     v2_x,
  output logic [COORD_BITS+FRAC_BITS:0]     v2_y,
  output logic [COORD_BITS+FRAC_BITS:0]     v2_z,
  output logic                              last_triangle
);

  localparam int OW = COORD_BITS + FRAC_BITS + 1;
  localparam int DW = (COORD_BITS + 18 > 26) ? COORD_BITS + 18 : 26;
  localparam int UW = DW + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  hmc_state_t state, state_next;

  logic [15:0]             iso_level;
  logic [7:0]              chunk_height;
  logic [COORD_BITS-1:0]   cpos [3];
  logic [15:0]             hgt [4];
  logic [23:0]             prod [4];
  logic [1:0]              mcnt;
  logic signed [DW-1:0]    dens [8];
  logic [7:0]              mask;
  tri_entry_t              ent;
  logic [2:0]              tri_idx;
  logic [1:0]              vsel;
  logic signed [DW-1:0]    da, db;
  logic [2:0]              pa, pb;
  logic [UW-1:0]           rem, den;
  logic [FRAC_BITS:0]      quo;
  logic [CW-1:0]           dcnt;
  logic [FRAC_BITS:0]      tval;
  logic [OW-1:0]           vtx [3][3];

  logic signed [DW-1:0]    iso;
  logic signed [DW-1:0]    dens_next [8];
  logic [7:0]              mask_next;
  tri_entry_t              ent_next;
  logic [3:0]              eidx, edge_code;
  logic signed [DW:0]      d_num, d_den;
  logic [UW-1:0]           num_abs, den_abs;
  logic                    hit_a, hit_b, flat, sat;
  logic [UW:0]             rem2;
  logic                    take;
  logic [FRAC_BITS:0]      quo_next;
  logic                    is_last;

  assign iso = DW'($signed({iso_level, 8'd0}));

  always_comb begin
    logic [2:0]            p;
    logic [COORD_BITS:0]   y;
    mask_next = '0;
    for (int c = 0; c < 8; c++) begin
      p = CORNER_POS[c];
      y = (COORD_BITS+1)'(cpos[1]) + (COORD_BITS+1)'(p[1]);
      dens_next[c] = $signed(DW'({y, 16'd0})) - $signed(DW'(prod[{p[2], p[0]}]));
      mask_next[c] = dens_next[c] < iso;
    end
  end

  assign ent_next  = tri_lookup(mask);
  assign eidx      = 4'({1'b0, tri_idx} * 4'd3) + 4'(vsel);
  assign edge_code = ent.edges[eidx];

  assign hit_a   = da == iso;
  assign hit_b   = db == iso;
  assign flat    = da == db;
  assign d_num   = (DW+1)'(iso) - (DW+1)'(da);
  assign d_den   = (DW+1)'(db) - (DW+1)'(da);
  assign num_abs = d_num[DW] ? UW'(-d_num) : UW'(d_num);
  assign den_abs = d_den[DW] ? UW'(-d_den) : UW'(d_den);
  assign sat     = num_abs >= den_abs;

  assign rem2     = {rem, 1'b0};
  assign take     = rem2 >= (UW+1)'(den);
  assign quo_next = {quo[FRAC_BITS-1:0], take};
  assign is_last  = tri_idx == ent.ntri - 3'd1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_MUL;
      S_MUL:  if (mcnt == 2'd3) state_next = S_DENS;
      S_DENS: state_next = S_LOOK;
      S_LOOK: state_next = (ent_next.ntri == 3'd0) ? S_IDLE : S_SEL;
      S_SEL:  state_next = S_PREP;
      S_PREP: state_next = (hit_a || hit_b || flat || sat) ? S_VERT : S_DIV;
      S_DIV:  if (dcnt == CW'(FRAC_BITS)) state_next = S_VERT;
      S_VERT: state_next = (vsel == 2'd2) ? S_OUT : S_SEL;
      S_OUT:  if (out_ready) state_next = is_last ? S_IDLE : S_SEL;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == S_IDLE;
    out_valid = state == S_OUT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      iso_level    <= '0;
      chunk_height <= 8'd64;
      mcnt         <= '0;
      tri_idx      <= '0;
      vsel         <= '0;
      dcnt         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == REG_ISO_LEVEL) iso_level <= cfg_data;
      if (cfg_we && cfg_index == REG_CHUNK_HEIGHT) chunk_height <= cfg_data[7:0];
      case (state)
        S_IDLE: begin
          mcnt    <= '0;
          tri_idx <= '0;
          vsel    <= '0;
        end
        S_MUL:  mcnt <= mcnt + 2'd1;
        S_PREP: dcnt <= '0;
        S_DIV:  dcnt <= dcnt + CW'(1);
        S_VERT: if (vsel != 2'd2) vsel <= vsel + 2'd1;
        S_OUT: begin
          if (out_ready) begin
            tri_idx <= tri_idx + 3'd1;
            vsel    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cpos[0] <= COORD_BITS'(cell_x);
        cpos[1] <= COORD_BITS'(cell_y);
        cpos[2] <= COORD_BITS'(cell_z);
        hgt[0]  <= height_00;
        hgt[1]  <= height_10;
        hgt[2]  <= height_01;
        hgt[3]  <= height_11;
      end
      S_MUL: prod[mcnt] <= 24'(hgt[mcnt]) * 24'(chunk_height);
      S_DENS: begin
        dens <= dens_next;
        mask <= mask_next;
      end
      S_LOOK: ent <= ent_next;
      S_SEL: begin
        da <= dens[EDGE_LO[edge_code]];
        db <= dens[EDGE_HI[edge_code]];
        pa <= CORNER_POS[EDGE_LO[edge_code]];
        pb <= CORNER_POS[EDGE_HI[edge_code]];
      end
      S_PREP: begin
        rem <= num_abs;
        den <= den_abs;
        quo <= '0;
        if (hit_a) tval <= '0;
        else if (hit_b) tval <= ONE;
        else if (flat) tval <= '0;
        else tval <= ONE;
      end
      S_DIV: begin
        rem <= take ? UW'(rem2 - (UW+1)'(den)) : UW'(rem2);
        quo <= quo_next;
        tval <= (FRAC_BITS+1)'(((FRAC_BITS+2)'(quo_next) + (FRAC_BITS+2)'(1)) >> 1);
      end
      S_VERT: begin
        for (int ax = 0; ax < 3; ax++) begin
          if (pb[ax] && !pa[ax])
            vtx[vsel][ax] <= ((OW'(cpos[ax]) + OW'(pa[ax])) << FRAC_BITS) + OW'(tval);
          else if (pa[ax] && !pb[ax])
            vtx[vsel][ax] <= ((OW'(cpos[ax]) + OW'(pa[ax])) << FRAC_BITS) - OW'(tval);
          else
            vtx[vsel][ax] <= (OW'(cpos[ax]) + OW'(pa[ax])) << FRAC_BITS;
        end
      end
      default: ;
    endcase
  end

  assign v0_x = vtx[0][0];
  assign v0_y = vtx[0][1];
  assign v0_z = vtx[0][2];
  assign v1_x = vtx[1][0];
  assign v1_y = vtx[1][1];
  assign v1_z = vtx[1][2];
  assign v2_x = vtx[2][0];
  assign v2_y = vtx[2][1];
  assign v2_z = vtx[2][2];
  assign last_triangle = is_last;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_busy: assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !in_ready)
    else $error("ready right after input transfer");
  a_div_rem: assert property (@(posedge clk) disable iff (rst) state == S_DIV |-> rem < den)
    else $error("divider remainder out of range");
  a_tri_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tri_idx < ent.ntri)
    else $error("triangle beyond list");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for heightfield_marching_cubes.
// Streams cube cells over valid/ready under several iso_level/chunk_height settings and
// checks each triangle against an in-bench predictor; uses hmc_pkg tables.
module tb_top
  import hmc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  x, y, z;
    logic [15:0] h00, h10, h01, h11;
  } cube_t;

  typedef struct {
    logic [16:0] c[9];
    logic        last;
  } tri_t;

  typedef struct {
    cube_t cube;
    int    ntri;  // -1: predictor only
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = REG_ISO_LEVEL;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  cell_x = '0, cell_y = '0, cell_z = '0;
  logic [15:0] height_00 = '0, height_10 = '0, height_01 = '0, height_11 = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [16:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
  logic        last_triangle;

  heightfield_marching_cubes uut (.*);

  always #5 clk = ~clk;

  tri_t        tri_fifo[$];
  logic [15:0] iso_sh = 16'd0;
  logic [7:0]  chunk_sh = 8'd64;
  bit          failed = 0;
  bit          idle_en = 1;
  int          stall_left = 0;

  function automatic int predict_cube(cube_t cb);
    longint dens[8];
    longint iso, one, t, num, den, base;
    longint cc[3];
    longint hh[4];
    logic [119:0] s;
    logic [7:0] ch;
    logic [3:0] e;
    logic [2:0] pa, pb;
    logic [7:0] mask;
    int len, ntri;
    tri_t tr;
    one = 256;
    cc[0] = cb.x; cc[1] = cb.y; cc[2] = cb.z;
    hh[0] = cb.h00; hh[1] = cb.h10; hh[2] = cb.h01; hh[3] = cb.h11;
    iso = longint'($signed(iso_sh)) * 256;
    mask = '0;
    for (int k = 0; k < 8; k++) begin
      pa = CORNER_POS[k];
      dens[k] = (cc[1] + pa[1]) * 65536 - hh[pa[0] + 2 * pa[2]] * longint'(chunk_sh);
      if (dens[k] < iso) mask[k] = 1'b1;
    end
    s = TRI_LIST[mask];
    len = 0;
    for (int i = 0; i < 15; i++) if (s[i*8 +: 8] != 8'd0) len++;
    ntri = len / 3;
    for (int k = 0; k < ntri; k++) begin
      for (int v = 0; v < 3; v++) begin
        ch = s[(len - 1 - (3 * k + v)) * 8 +: 8];
        e = (ch >= "a") ? 4'(ch - 8'd87) : 4'(ch - 8'd48);
        pa = CORNER_POS[EDGE_LO[e]];
        pb = CORNER_POS[EDGE_HI[e]];
        if (dens[EDGE_LO[e]] == iso) t = 0;
        else if (dens[EDGE_HI[e]] == iso) t = one;
        else if (dens[EDGE_LO[e]] == dens[EDGE_HI[e]]) t = 0;
        else begin
          num = iso - dens[EDGE_LO[e]];
          if (num < 0) num = -num;
          den = dens[EDGE_HI[e]] - dens[EDGE_LO[e]];
          if (den < 0) den = -den;
          t = ((num << 9) + den) / (den * 2);
          if (t > one) t = one;
        end
        for (int a = 0; a < 3; a++) begin
          base = (cc[a] + pa[a]) << 8;
          if (pb[a] > pa[a]) base += t;
          else if (pb[a] < pa[a]) base -= t;
          tr.c[3 * v + a] = 17'(base);
        end
      end
      tr.last = (k + 1 == ntri);
      tri_fifo = {tri_fifo, tr};
    end
    return ntri;
  endfunction

  // receiver with random stall bursts, checks every transfer
  always @(posedge clk) begin
    tri_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.c = '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z};
        got.last = last_triangle;
        if (tri_fifo.size() == 0) begin
          $display("%0t: unexpected triangle transfer", $realtime);
          failed = 1;
        end else begin
          want = tri_fifo.pop_front();
          for (int i = 0; i < 9; i++)
            if (got.c[i] !== want.c[i]) begin
              $display("%0t: coord %0d expected %0d actual %0d", $realtime, i,
                       want.c[i], got.c[i]);
              failed = 1;
            end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $realtime, want.last, got.last);
            failed = 1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 11);
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  task automatic send_cube(cube_t cb, int ntri);
    int n;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    n = predict_cube(cb);
    if (ntri >= 0 && n != ntri) begin
      $display("%0t: triangle count expected %0d actual %0d", $realtime, ntri, n);
      failed = 1;
    end
    in_valid <= 1;
    cell_x <= cb.x; cell_y <= cb.y; cell_z <= cb.z;
    height_00 <= cb.h00; height_10 <= cb.h10; height_01 <= cb.h01; height_11 <= cb.h11;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (tri_fifo.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] iso, logic [7:0] chunk);
    drain();
    cfg_we <= 1; cfg_index <= REG_ISO_LEVEL; cfg_data <= iso;
    @(posedge clk);
    cfg_index <= REG_CHUNK_HEIGHT; cfg_data <= {8'd0, chunk};
    @(posedge clk);
    cfg_we <= 0;
    iso_sh = iso;
    chunk_sh = chunk;
  endtask

  // surface-crossing cube: cell_y near the height, corners usually close together
  function automatic cube_t near_surface();
    cube_t cb;
    longint h, y;
    int d;
    d = $urandom_range(0, 3) == 0 ? 65535 : 4096;
    h = $urandom_range(0, 65535);
    cb.x = 8'($urandom); cb.z = 8'($urandom);
    cb.h00 = 16'(h);
    cb.h10 = 16'(h + $urandom_range(0, d));
    cb.h01 = 16'(h + $urandom_range(0, d));
    cb.h11 = 16'(h + $urandom_range(0, d));
    y = ((h * chunk_sh + longint'($signed(iso_sh)) * 256) >>> 16)
        + longint'($urandom_range(0, 2)) - 1;
    if (y < 0) y = 0;
    if (y > 255) y = 255;
    cb.y = 8'(y);
    return cb;
  endfunction

  task automatic random_cubes(int count, bit hold_once);
    cube_t cb;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        cb.x = 8'($urandom); cb.y = 8'($urandom); cb.z = 8'($urandom);
        cb.h00 = 16'($urandom); cb.h10 = 16'($urandom);
        cb.h01 = 16'($urandom); cb.h11 = 16'($urandom);
      end else cb = near_surface();
      send_cube(cb, -1);
      if (hold_once && i == count / 2) begin
        in_valid <= 0;
        do @(posedge clk); while (tri_fifo.size() != 0);
      end
    end
  endtask

  row_t rows[] = '{
    '{'{8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 0},
    '{'{8'd0, 8'd0, 8'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff}, 0},
    '{'{8'd255, 8'd255, 8'd255, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 0},
    '{'{8'd0, 8'd31, 8'd0, 16'h8000, 16'h0000, 16'h0000, 16'h0000}, 1},
    '{'{8'd3, 8'd31, 8'd7, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, -1},
    '{'{8'd255, 8'd31, 8'd255, 16'h8000, 16'h7c00, 16'h8400, 16'h7000}, -1},
    '{'{8'd10, 8'd20, 8'd30, 16'h5000, 16'h5200, 16'h4e00, 16'h5100}, -1},
    '{'{8'd255, 8'd63, 8'd0, 16'hffff, 16'hfc00, 16'hf800, 16'hffff}, -1},
    '{'{8'd128, 8'd0, 8'd128, 16'h0200, 16'h0000, 16'h0500, 16'h0000}, -1},
    '{'{8'd1, 8'd31, 8'd2, 16'h7fff, 16'h8001, 16'h8000, 16'h7f00}, -1},
    '{'{8'd85, 8'd40, 8'd170, 16'ha000, 16'ha100, 16'h9f00, 16'ha080}, -1},
    '{'{8'd0, 8'd15, 8'd255, 16'h4000, 16'h0000, 16'hffff, 16'h3c00}, -1}
  };

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) send_cube(rows[i].cube, rows[i].ntri);
    write_regs(16'h0000, 8'd255);
    send_cube('{8'd255, 8'd254, 8'd255, 16'hffff, 16'hfe00, 16'hff00, 16'hfd00}, -1);
    random_cubes(20, 1);
    write_regs(16'h8000, 8'd255);
    random_cubes(15, 0);
    write_regs(16'h7fff, 8'd1);
    random_cubes(15, 0);
    write_regs(16'($urandom), 8'($urandom_range(1, 255)));
    random_cubes(20, 0);
    write_regs(16'h0180, 8'd64);
    idle_en = 0;
    random_cubes(27, 0);
    drain();
    if (!failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end
endmodule
